/* hdl/gcr_pkg.sv */
// Shared types, constants and helper functions for the two-level grid rank block.
`timescale 1ns / 1ps
package gcr_pkg;

  localparam int unsigned MAX_EXTENT = 256;
  localparam int unsigned EXT_W      = 9;
  localparam int unsigned COORD_W    = 8;
  localparam int unsigned RANK_W     = 24;
  localparam int unsigned CPN_W      = 25;
  localparam int unsigned ORDER_W    = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 25;
  localparam int unsigned DIV_STAGES = 3;
  localparam int unsigned DIV_STEPS  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_X = 3'd0,
    REG_GRID_Y = 3'd1,
    REG_GRID_Z = 3'd2,
    REG_CORE_X = 3'd3,
    REG_CORE_Y = 3'd4,
    REG_CORE_Z = 3'd5,
    REG_CPN    = 3'd6,
    REG_ORDER  = 3'd7
  } cfg_reg_t;

  typedef enum logic [ORDER_W-1:0] {
    ORD_XYZ = 3'd0,
    ORD_XZY = 3'd1,
    ORD_YXZ = 3'd2,
    ORD_YZX = 3'd3,
    ORD_ZXY = 3'd4,
    ORD_ZYX = 3'd5
  } axis_order_t;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_z;
  } in_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              coord_error;
  } out_t;

  // Fastest, middle and slowest axis of a linearization.
  typedef struct packed {
    logic [1:0] fast;
    logic [1:0] mid;
    logic [1:0] slow;
  } order_sel_t;

  function automatic order_sel_t order_lookup(input logic [ORDER_W-1:0] code);
    order_sel_t o;
    case (code)
      ORD_XZY: o = '{fast: AXIS_X, mid: AXIS_Z, slow: AXIS_Y};
      ORD_YXZ: o = '{fast: AXIS_Y, mid: AXIS_X, slow: AXIS_Z};
      ORD_YZX: o = '{fast: AXIS_Y, mid: AXIS_Z, slow: AXIS_X};
      ORD_ZXY: o = '{fast: AXIS_Z, mid: AXIS_X, slow: AXIS_Y};
      ORD_ZYX: o = '{fast: AXIS_Z, mid: AXIS_Y, slow: AXIS_X};
      default: o = '{fast: AXIS_X, mid: AXIS_Y, slow: AXIS_Z};
    endcase
    return o;
  endfunction

  function automatic logic [EXT_W-1:0] clamp_extent(input logic [EXT_W-1:0] v);
    return (v > EXT_W'(MAX_EXTENT)) ? EXT_W'(MAX_EXTENT) : v;
  endfunction

  function automatic logic [EXT_W-1:0] core_eff(input logic [EXT_W-1:0] v);
    logic [EXT_W-1:0] c;
    c = clamp_extent(v);
    return (c == '0) ? EXT_W'(1) : c;
  endfunction

endpackage

/* hdl/gcr_div.sv */
// Pipelined restoring divider: 9-bit dividend by 9-bit divisor, three bits per stage.
`timescale 1ns / 1ps
module gcr_div (
  input  logic                  clk,
  input  logic                  en,
  input  logic [gcr_pkg::EXT_W-1:0] dividend,
  input  logic [gcr_pkg::EXT_W-1:0] divisor,
  output logic [gcr_pkg::EXT_W-1:0] quotient,
  output logic [gcr_pkg::EXT_W-1:0] remainder
);
  import gcr_pkg::*;

  // dq holds the dividend bits still to be consumed, with quotient bits shifted in.
  logic [EXT_W-1:0] rem_r [DIV_STAGES];
  logic [EXT_W-1:0] dq_r  [DIV_STAGES];
  logic [EXT_W-1:0] rem_nxt [DIV_STAGES];
  logic [EXT_W-1:0] dq_nxt  [DIV_STAGES];

  always_comb begin
    logic [EXT_W:0]   trial;
    logic [EXT_W-1:0] rem_v;
    logic [EXT_W-1:0] dq_v;
    for (int s = 0; s < DIV_STAGES; s++) begin
      rem_v = (s == 0) ? '0 : rem_r[(s == 0) ? 0 : s-1];
      dq_v  = (s == 0) ? dividend : dq_r[(s == 0) ? 0 : s-1];
      for (int k = 0; k < DIV_STEPS; k++) begin
        trial = {rem_v, dq_v[EXT_W-1]};
        dq_v  = {dq_v[EXT_W-2:0], 1'b0};
        if (trial >= {1'b0, divisor}) begin
          trial   = trial - {1'b0, divisor};
          dq_v[0] = 1'b1;
        end
        rem_v = trial[EXT_W-1:0];
      end
      rem_nxt[s] = rem_v;
      dq_nxt[s]  = dq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        rem_r[s] <= rem_nxt[s];
        dq_r[s]  <= dq_nxt[s];
      end
    end
  end

  assign quotient  = dq_r[DIV_STAGES-1];
  assign remainder = rem_r[DIV_STAGES-1];

endmodule

/* hdl/grid_coord_to_rank_two_level.sv */
// Top level: two-level linear rank of a 3D grid coordinate.
// Throughput: one request per cycle; a stalled output freezes the whole pipeline.
// Stages 1-3 are the shared-shape dividers, 4-6 the three multiplies, 7 the output add.
// Reset (synchronous, rst_n low) clears all stage valid bits and sets sizes and
// cores_per_node to 1 and the axis order to xyz.
`timescale 1ns / 1ps
module grid_coord_to_rank_two_level (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  gcr_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output gcr_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic [gcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gcr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import gcr_pkg::*;

  localparam int unsigned NSTG = 7;

  // Configuration registers.
  logic [EXT_W-1:0]   grid_r [3];
  logic [EXT_W-1:0]   core_r [3];
  logic [CPN_W-1:0]   cpn_r;
  logic [ORDER_W-1:0] order_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        grid_r[a] <= EXT_W'(1);
        core_r[a] <= EXT_W'(1);
      end
      cpn_r   <= CPN_W'(1);
      order_r <= ORD_XYZ;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_X: grid_r[0] <= cfg_wdata[EXT_W-1:0];
        REG_GRID_Y: grid_r[1] <= cfg_wdata[EXT_W-1:0];
        REG_GRID_Z: grid_r[2] <= cfg_wdata[EXT_W-1:0];
        REG_CORE_X: core_r[0] <= cfg_wdata[EXT_W-1:0];
        REG_CORE_Y: core_r[1] <= cfg_wdata[EXT_W-1:0];
        REG_CORE_Z: core_r[2] <= cfg_wdata[EXT_W-1:0];
        REG_CPN:    cpn_r     <= cfg_wdata[CPN_W-1:0];
        REG_ORDER:  order_r   <= cfg_wdata[ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective extents. Configuration must only change while the pipeline is empty
  // (the block does not enforce this), so every stage may read these directly.
  logic [EXT_W-1:0] gs [3];
  logic [EXT_W-1:0] cs [3];
  logic [EXT_W-1:0] coord [3];
  always_comb begin
    coord[0] = EXT_W'(in_data.coord_x);
    coord[1] = EXT_W'(in_data.coord_y);
    coord[2] = EXT_W'(in_data.coord_z);
    for (int a = 0; a < 3; a++) begin
      gs[a] = clamp_extent(grid_r[a]);
      cs[a] = core_eff(core_r[a]);
    end
  end

  // The whole pipeline advances together unless the result is held.
  logic            adv;
  logic [NSTG-1:0] vld_r;
  logic [NSTG-2:0] err_r;
  logic            err_in;

  assign adv      = !vld_r[NSTG-1] || out_ready;
  assign in_ready = adv;
  assign err_in   = (coord[0] >= gs[0]) || (coord[1] >= gs[1]) || (coord[2] >= gs[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      err_r <= {err_r[NSTG-3:0], err_in};
    end
  end

  // Stages 1-3: node and core coordinates, and node counts of the grid.
  logic [EXT_W-1:0] node_q [3];
  logic [EXT_W-1:0] core_q [3];
  logic [EXT_W-1:0] nx_q   [3];
  logic [EXT_W-1:0] nx_rem [3];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    gcr_div u_coord_div (
      .clk       (clk),
      .en        (adv),
      .dividend  (coord[a]),
      .divisor   (cs[a]),
      .quotient  (node_q[a]),
      .remainder (core_q[a])
    );
    gcr_div u_grid_div (
      .clk       (clk),
      .en        (adv),
      .dividend  (gs[a]),
      .divisor   (cs[a]),
      .quotient  (nx_q[a]),
      .remainder (nx_rem[a])
    );
  end

  // Stage 4: slowest index times middle extent, for both levels.
  order_sel_t ord;
  assign ord = order_lookup(order_r);

  logic [2*EXT_W-1:0] pn_r, pc_r;
  logic [EXT_W-1:0]   nm_r, nf_r, nxf_r, cm_r, cf_r, csf_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pn_r  <= (2*EXT_W)'(node_q[ord.slow]) * (2*EXT_W)'(nx_q[ord.mid]);
      pc_r  <= (2*EXT_W)'(core_q[ord.slow]) * (2*EXT_W)'(cs[ord.mid]);
      nm_r  <= node_q[ord.mid];
      nf_r  <= node_q[ord.fast];
      nxf_r <= nx_q[ord.fast];
      cm_r  <= core_q[ord.mid];
      cf_r  <= core_q[ord.fast];
      csf_r <= cs[ord.fast];
    end
  end

  // Stage 5: finish both linear indices.
  logic [3*EXT_W:0] ni_full, ci_full;
  logic [RANK_W-1:0] ni_r, ci_r, ci2_r;

  always_comb begin
    ni_full = ((3*EXT_W+1)'(pn_r) + (3*EXT_W+1)'(nm_r)) * (3*EXT_W+1)'(nxf_r)
              + (3*EXT_W+1)'(nf_r);
    ci_full = ((3*EXT_W+1)'(pc_r) + (3*EXT_W+1)'(cm_r)) * (3*EXT_W+1)'(csf_r)
              + (3*EXT_W+1)'(cf_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ni_r <= ni_full[RANK_W-1:0];
      ci_r <= ci_full[RANK_W-1:0];
    end
  end

  // Stage 6: node stride; only the low rank bits survive the final wrap.
  logic [2*RANK_W-1:0] prod_full;
  logic [RANK_W-1:0]   prod_r;
  assign prod_full = (2*RANK_W)'(cpn_r[RANK_W-1:0]) * (2*RANK_W)'(ni_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_full[RANK_W-1:0];
      ci2_r  <= ci_r;
    end
  end

  // Stage 7: output register.
  out_t out_r, out_nxt;
  always_comb begin
    out_nxt.coord_error = err_r[NSTG-2];
    out_nxt.rank        = err_r[NSTG-2] ? '0 : prod_r + ci2_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = vld_r[NSTG-1];
  assign out_data  = out_r;

  // An out-of-range coordinate never produces a nonzero rank.
  a_err_rank_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.coord_error |-> out_data.rank == '0)
    else $error("coord_error with nonzero rank");

  // While the output is held, no request enters or leaves any stage.
  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(vld_r))
    else $error("pipeline moved during stall");

endmodule

/* tb/grid_coord_to_rank_two_level_tb.sv */
// Self-checking testbench for the two-level grid coordinate to rank block.
`timescale 1ns / 1ps
module grid_coord_to_rank_two_level_tb;
  import gcr_pkg::*;

  // The block has a seven-stage pipeline; idle waits use a margin above that.
  localparam int PIPE_DEPTH   = 7;
  localparam int DRAIN_CYCLES = 40;
  localparam int N_RANDOM     = 1800;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  grid_coord_to_rank_two_level dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // Shadow copy of the configuration, kept as the raw register values.
  logic [EXT_W-1:0] grid_sz [3];
  logic [EXT_W-1:0] core_sz [3];
  logic [CPN_W-1:0] rank_stride;
  logic [ORDER_W-1:0] order_code;

  in_t  pending_requests [$];
  out_t expected_ranks [$];
  int   error_count = 0;
  int   checked_count = 0;
  int   error_results = 0;
  bit   send_idle_ok = 1'b1;   // random sender gaps allowed
  bit   recv_idle_ok = 1'b1;   // random receiver stalls allowed
  int   recv_hold = 0;         // cycles the receiver still holds off

  function automatic logic [EXT_W-1:0] eff_extent(input logic [EXT_W-1:0] v);
    return (v > 9'd256) ? 9'd256 : v;
  endfunction

  function automatic logic [EXT_W-1:0] eff_core(input logic [EXT_W-1:0] v);
    logic [EXT_W-1:0] c;
    c = eff_extent(v);
    return (c == 9'd0) ? 9'd1 : c;
  endfunction

  // Linearize three per-axis indices; the first axis of the order varies fastest.
  function automatic longint unsigned linearize(input longint unsigned idx [3],
                                                input longint unsigned ext [3],
                                                input int f, input int m, input int s);
    return (idx[s] * ext[m] + idx[m]) * ext[f] + idx[f];
  endfunction

  // Computes the expected rank and error flag for one coordinate.
  function automatic out_t predict_rank(input in_t c);
    longint unsigned crd [3], gs [3], cs [3], nodes [3], node_idx [3], core_idx [3];
    longint unsigned full;
    int f, m, s;
    bit bad;
    out_t r;
    crd[0] = 64'(c.coord_x); crd[1] = 64'(c.coord_y); crd[2] = 64'(c.coord_z);
    bad = 1'b0;
    for (int a = 0; a < 3; a++) begin
      gs[a] = 64'(eff_extent(grid_sz[a]));
      cs[a] = 64'(eff_core(core_sz[a]));
      nodes[a] = (gs[a] / cs[a]) & 9'h1FF;
      if (crd[a] >= gs[a]) bad = 1'b1;
      node_idx[a] = crd[a] / cs[a];
      core_idx[a] = crd[a] % cs[a];
    end
    case (order_code)
      ORD_XZY: begin f = 0; m = 2; s = 1; end
      ORD_YXZ: begin f = 1; m = 0; s = 2; end
      ORD_YZX: begin f = 1; m = 2; s = 0; end
      ORD_ZXY: begin f = 2; m = 0; s = 1; end
      ORD_ZYX: begin f = 2; m = 1; s = 0; end
      default: begin f = 0; m = 1; s = 2; end
    endcase
    full = longint'(rank_stride) * linearize(node_idx, nodes, f, m, s)
         + linearize(core_idx, cs, f, m, s);
    r.rank = bad ? '0 : full[RANK_W-1:0];
    r.coord_error = bad;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    error_count++;
  endtask

  // Driver: presents the oldest pending request; the prediction is taken on acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_ranks.push_back(predict_rank(in_data));
      if (!in_valid || in_ready) begin
        if (pending_requests.size() > 0 &&
            !(send_idle_ok && $urandom_range(99) < 10)) begin
          in_data  <= pending_requests.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_ranks.size() == 0) begin
          report_mismatch($sformatf("unexpected result rank=%0d err=%0b",
                                    out_data.rank, out_data.coord_error));
        end else begin
          out_t e;
          e = expected_ranks.pop_front();
          checked_count++;
          if (e.coord_error) error_results++;
          if (out_data.rank !== e.rank)
            report_mismatch($sformatf("rank %0d, expected %0d", out_data.rank, e.rank));
          if (out_data.coord_error !== e.coord_error)
            report_mismatch($sformatf("coord_error %0b, expected %0b",
                                      out_data.coord_error, e.coord_error));
        end
      end
      // A long hold-off is counted here; otherwise the receiver stalls at random if allowed.
      if (recv_hold > 0) begin
        recv_hold <= recv_hold - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(recv_idle_ok && $urandom_range(99) < 10);
      end
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_GRID_X: grid_sz[0] = val[EXT_W-1:0];
      REG_GRID_Y: grid_sz[1] = val[EXT_W-1:0];
      REG_GRID_Z: grid_sz[2] = val[EXT_W-1:0];
      REG_CORE_X: core_sz[0] = val[EXT_W-1:0];
      REG_CORE_Y: core_sz[1] = val[EXT_W-1:0];
      REG_CORE_Z: core_sz[2] = val[EXT_W-1:0];
      REG_CPN:    rank_stride = val[CPN_W-1:0];
      REG_ORDER:  order_code = val[ORDER_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_setup(input int gx, gy, gz, cx, cy, cz, input int cpn, input int ord);
    write_reg(REG_GRID_X, CFG_DATA_W'(gx));
    write_reg(REG_GRID_Y, CFG_DATA_W'(gy));
    write_reg(REG_GRID_Z, CFG_DATA_W'(gz));
    write_reg(REG_CORE_X, CFG_DATA_W'(cx));
    write_reg(REG_CORE_Y, CFG_DATA_W'(cy));
    write_reg(REG_CORE_Z, CFG_DATA_W'(cz));
    write_reg(REG_CPN, CFG_DATA_W'(cpn));
    write_reg(REG_ORDER, CFG_DATA_W'(ord));
  endtask

  // Blocks until every queued request has produced its result, then lets the pipe settle.
  // The check runs just after each edge so that the driver's updates have landed.
  task automatic wait_quiet();
    while (pending_requests.size() > 0 || in_valid || expected_ranks.size() > 0) begin
      @(posedge clk);
      #1;
    end
    repeat (PIPE_DEPTH + 3) @(posedge clk);
  endtask

  function automatic in_t coord(input int x, y, z);
    in_t c;
    c.coord_x = COORD_W'(x); c.coord_y = COORD_W'(y); c.coord_z = COORD_W'(z);
    return c;
  endfunction

  // Mostly in-range coordinates, with some anywhere in the 8-bit space.
  function automatic in_t random_coord();
    in_t c;
    logic [EXT_W-1:0] g [3];
    int v [3];
    for (int a = 0; a < 3; a++) begin
      g[a] = eff_extent(grid_sz[a]);
      if (g[a] == 0 || $urandom_range(99) < 12) v[a] = $urandom_range(255);
      else v[a] = $urandom_range(g[a] - 1);
    end
    return coord(v[0], v[1], v[2]);
  endfunction

  // Grid extents that are mostly multiples of the core size, plus oddities.
  task automatic random_setup();
    int c [3], g [3], cpn;
    for (int a = 0; a < 3; a++) begin
      c[a] = $urandom_range(1, 8);
      g[a] = c[a] * $urandom_range(1, 256 / c[a]);
      case ($urandom_range(15))
        0: g[a] = $urandom_range(511);        // above the maximum, zero or non-divisible
        1: c[a] = $urandom_range(511);
        2: c[a] = 0;
        default: ;
      endcase
    end
    cpn = ($urandom_range(7) == 0) ? $urandom_range(32'h1FF_FFFF) : c[0] * c[1] * c[2];
    load_setup(g[0], g[1], g[2], c[0], c[1], c[2], cpn, $urandom_range(7));
  endtask

  initial begin
    int phase_items;
    grid_sz = '{9'd1, 9'd1, 9'd1};
    core_sz = '{9'd1, 9'd1, 9'd1};
    rank_stride = CPN_W'(1);
    order_code = ORD_XYZ;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset setup: only the origin is in range.
    pending_requests.push_back(coord(0, 0, 0));
    pending_requests.push_back(coord(1, 0, 0));
    wait_quiet();

    // Largest grid with 4x4x4 cores: extremes of every coordinate, every order.
    load_setup(256, 256, 256, 4, 4, 4, 64, ORD_XYZ);
    for (int o = 0; o < 8; o++) begin
      write_reg(REG_ORDER, CFG_DATA_W'(o));
      pending_requests.push_back(coord(255, 255, 255));
      pending_requests.push_back(coord(1, 2, 3));
      pending_requests.push_back(coord(170, 85, 0));
      wait_quiet();
    end

    // Extents above the maximum, a zero grid size, zero core size and zero stride.
    load_setup(511, 300, 0, 0, 7, 511, 0, ORD_ZYX);
    pending_requests.push_back(coord(255, 10, 0));
    wait_quiet();
    write_reg(REG_GRID_Z, CFG_DATA_W'(256));
    pending_requests.push_back(coord(255, 10, 100));
    pending_requests.push_back(coord(0, 255, 255));
    wait_quiet();
    // One-level map with a full 25-bit stride so that the rank wraps.
    load_setup(256, 256, 256, 1, 1, 1, 25'h1FF_FFFF, ORD_YZX);
    pending_requests.push_back(coord(255, 255, 255));
    pending_requests.push_back(coord(0, 0, 0));
    wait_quiet();
    // Every register index maps to a register, so there is no nonexistent slot to write.

    // Random phases under changing setups. The first phase runs with no random
    // gaps on either side and always includes a long receiver hold-off.
    phase_items = 0;
    while (phase_items < N_RANDOM) begin
      int n;
      random_setup();
      if (phase_items == 0) begin
        n = 300;
        send_idle_ok = 1'b0;
        recv_idle_ok = 1'b0;
      end else begin
        n = $urandom_range(60, 180);
        send_idle_ok = ($urandom_range(4) != 0);
        recv_idle_ok = ($urandom_range(4) != 0);
      end
      for (int i = 0; i < n; i++) pending_requests.push_back(random_coord());
      // The receiver holds off long enough that the pipe fills up.
      if (phase_items == 0 || $urandom_range(3) == 0) recv_hold = $urandom_range(40, 120);
      phase_items += n;
      wait_quiet();   // the sender pauses until every result has come
    end
    send_idle_ok = 1'b1;
    recv_idle_ok = 1'b1;

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d results (%0d with coordinate errors) over random setups,",
             checked_count, error_results);
    $display("all axis orders, clamped and zero extents, and long output stalls.");
    if (error_count == 0 && expected_ranks.size() == 0) begin
      $display("grid_coord_to_rank_two_level_tb: done, clean");
    end else begin
      $display("grid_coord_to_rank_two_level_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout: run did not finish.");
    $display("grid_coord_to_rank_two_level_tb: done, errors");
    $finish;
  end

endmodule

/* sim.f */
hdl/gcr_pkg.sv
hdl/gcr_div.sv
hdl/grid_coord_to_rank_two_level.sv
tb/grid_coord_to_rank_two_level_tb.sv
